@@ rtl/core/ffsa_pkg.sv @@
// shared types, widths and codes of the first-fit segment allocator
package ffsa_pkg;

   localparam int OFF_W  = 20;   // payload and header offsets
   localparam int SIZE_W = 21;   // payload size, holds a whole arena
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam int ARENA_BYTES_DEF = 1 << 20;
   localparam int HDR_BYTES_DEF   = 24;
   localparam int MAX_SEGS_DEF    = 64;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_NULL    = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_UP,
      S_UP_WR,
      S_REM_WR,
      S_MG_START,
      S_MG_LOAD,
      S_MG_CMP,
      S_DN,
      S_DN_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              free;
      logic [SIZE_W-1:0] size;
      logic [OFF_W-1:0]  start;
   } seg_entry_type;

   typedef struct packed {
      logic              fit;
      logic              split;
      logic              match;
      logic [OFF_W-1:0]  pay_off;
      logic [OFF_W-1:0]  rem_start;
      logic [SIZE_W-1:0] rem_size;
      logic [SIZE_W-1:0] merged_size;
   } alu_res_type;

endpackage

@@ rtl/core/ffsa_seg_alu.sv @@
// shared segment arithmetic: fit and split tests, offset match, split and merge sizes
module ffsa_seg_alu #(
   parameter int HDR_BYTES = ffsa_pkg::HDR_BYTES_DEF
) (
   input  ffsa_pkg::seg_entry_type        seg_a,
   input  ffsa_pkg::seg_entry_type        seg_b,
   input  logic [ffsa_pkg::SIZE_W-1:0]    want,
   input  logic [ffsa_pkg::OFF_W-1:0]     rel_off,
   output ffsa_pkg::alu_res_type          res
);

   localparam int SW = ffsa_pkg::SIZE_W + 1;
   localparam logic [SW-1:0] HDR_EXT = SW'(HDR_BYTES);

   logic [SW-1:0] want_hdr;
   logic [SW-1:0] size_a;
   logic [SW-1:0] pay_sum;

   assign want_hdr = SW'(want) + HDR_EXT;
   assign size_a   = SW'(seg_a.size);
   assign pay_sum  = SW'(seg_a.start) + HDR_EXT;

   always_comb begin
      res.fit         = seg_a.free && (seg_a.size >= want);
      res.split       = size_a > want_hdr;
      res.match       = pay_sum == SW'(rel_off);
      res.pay_off     = pay_sum[ffsa_pkg::OFF_W-1:0];
      res.rem_start   = ffsa_pkg::OFF_W'(SW'(seg_a.start) + want_hdr);
      res.rem_size    = ffsa_pkg::SIZE_W'(size_a - want_hdr);
      res.merged_size = ffsa_pkg::SIZE_W'(size_a + HDR_EXT + SW'(seg_b.size));
   end

endmodule

@@ rtl/core/first_fit_segment_allocator_core.sv @@
// first-fit segment allocator with coalescing: sequencer, segment table and result register
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser kind, tdata req_bytes, release_offset
//  rsp     | out | rsp_tvalid/tready    | tdata status, payload_offset
//
// one request at a time; the table lives in a 1r1w memory with registered read
// scan reads one segment at a time; every table shift reads and then rewrites each entry it moves
// allocate: scan for the first fit, then on a split move the entries above it up one place
// free: scan for the match, then a merge pass over the table moves later entries down per merge
// after reset the S_INIT state writes the initial free segment before req_tready rises
// a finished response waits in its register; a new request is taken while it waits
module first_fit_segment_allocator_core #(
   parameter int ARENA_BYTES = ffsa_pkg::ARENA_BYTES_DEF,
   parameter int HDR_BYTES   = ffsa_pkg::HDR_BYTES_DEF,
   parameter int MAX_SEGS    = ffsa_pkg::MAX_SEGS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,   // kind
   input  logic [ffsa_pkg::REQ_DATA_W-1:0]     req_tdata,   // req_bytes, release_offset, zeros
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ffsa_pkg::RSP_DATA_W-1:0]     rsp_tdata    // status, payload_offset, zero
);

   localparam int OFF_W  = ffsa_pkg::OFF_W;
   localparam int SIZE_W = ffsa_pkg::SIZE_W;
   localparam int IDX_W  = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEGS + 1);
   localparam int CW     = CNT_W + 1;
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HDR_BYTES);

   ffsa_pkg::state_type     state_ff, state_in;
   ffsa_pkg::kind_type      kind_ff, kind_in;
   logic [SIZE_W-1:0]       want_ff, want_in;
   logic [OFF_W-1:0]        rel_ff, rel_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   ffsa_pkg::seg_entry_type a_ff, a_in;
   ffsa_pkg::status_type    res_status_ff, res_status_in;
   logic [OFF_W-1:0]        res_off_ff, res_off_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]        rsp_off_ff, rsp_off_in;

   // segment table
   ffsa_pkg::seg_entry_type mem [MAX_SEGS];
   ffsa_pkg::seg_entry_type rd_ff;
   ffsa_pkg::seg_entry_type wr_data;
   logic                    wr_en, rd_en;
   logic [IDX_W-1:0]        wr_addr, rd_addr;

   ffsa_pkg::seg_entry_type alu_a;
   ffsa_pkg::alu_res_type   alu;

   logic [CW-1:0] idx_ext, cnt_ext, k_ext;

   assign idx_ext = CW'(idx_ff);
   assign cnt_ext = CW'(cnt_ff);
   assign k_ext   = CW'(k_ff);

   assign alu_a = (state_ff == ffsa_pkg::S_SCAN) ? rd_ff : a_ff;

   ffsa_seg_alu #(
      .HDR_BYTES (HDR_BYTES)
   ) u_alu (
      .seg_a   (alu_a),
      .seg_b   (rd_ff),
      .want    (want_ff),
      .rel_off (rel_ff),
      .res     (alu)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::S_INIT;
         cnt_ff       <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      want_ff       <= want_in;
      rel_ff        <= rel_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      a_ff          <= a_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      want_in       = want_ff;
      rel_in        = rel_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      a_in          = a_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = a_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      req_tready    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ffsa_pkg::S_INIT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.free  = 1'b1;
            wr_data.size  = INIT_SIZE;
            wr_data.start = '0;
            cnt_in        = CNT_W'(1);
            state_in      = ffsa_pkg::S_IDLE;
         end

         ffsa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in    = ffsa_pkg::kind_type'(req_tuser);
               want_in    = req_tdata[SIZE_W-1:0];
               rel_in     = req_tdata[SIZE_W+OFF_W-1:SIZE_W];
               res_off_in = '0;
               idx_in     = '0;
               if (req_tuser == ffsa_pkg::KIND_ALLOC && req_tdata[SIZE_W-1:0] == '0) begin
                  res_status_in = ffsa_pkg::ST_ZERO;
                  state_in      = ffsa_pkg::S_DONE;
               end else if (req_tuser == ffsa_pkg::KIND_FREE
                            && req_tdata[SIZE_W+OFF_W-1:SIZE_W] == '0) begin
                  res_status_in = ffsa_pkg::ST_NULL;
                  state_in      = ffsa_pkg::S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ffsa_pkg::S_SCAN;
               end
            end
         end

         // rd_ff holds entry idx_ff
         ffsa_pkg::S_SCAN: begin
            if (kind_ff == ffsa_pkg::KIND_ALLOC && alu.fit) begin
               a_in          = rd_ff;
               res_status_in = ffsa_pkg::ST_OK;
               res_off_in    = alu.pay_off;
               if (alu.split && cnt_ext < CW'(MAX_SEGS)) begin
                  k_in     = cnt_ff[IDX_W-1:0];
                  state_in = ffsa_pkg::S_UP;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = idx_ff;
                  wr_data      = rd_ff;
                  wr_data.free = 1'b0;
                  state_in     = ffsa_pkg::S_DONE;
               end
            end else if (kind_ff == ffsa_pkg::KIND_FREE && alu.match) begin
               wr_en         = 1'b1;
               wr_addr       = idx_ff;
               wr_data       = rd_ff;
               wr_data.free  = 1'b1;
               res_status_in = ffsa_pkg::ST_OK;
               state_in      = ffsa_pkg::S_MG_START;
            end else if (idx_ext + CW'(1) < cnt_ext) begin
               idx_in  = idx_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
            end else begin
               res_status_in = (kind_ff == ffsa_pkg::KIND_ALLOC) ? ffsa_pkg::ST_NOFIT
                                                                 : ffsa_pkg::ST_UNKNOWN;
               state_in      = ffsa_pkg::S_DONE;
            end
         end

         // open a hole at idx+1 by moving entries up one place
         ffsa_pkg::S_UP: begin
            if (k_ff != idx_ff + 1'b1) begin
               rd_en    = 1'b1;
               rd_addr  = k_ff - 1'b1;
               state_in = ffsa_pkg::S_UP_WR;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = k_ff;
               wr_data.free  = 1'b1;
               wr_data.size  = alu.rem_size;
               wr_data.start = alu.rem_start;
               state_in      = ffsa_pkg::S_REM_WR;
            end
         end

         ffsa_pkg::S_UP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_data  = rd_ff;
            k_in     = k_ff - 1'b1;
            state_in = ffsa_pkg::S_UP;
         end

         ffsa_pkg::S_REM_WR: begin
            wr_en         = 1'b1;
            wr_addr       = idx_ff;
            wr_data.free  = 1'b0;
            wr_data.size  = want_ff;
            wr_data.start = a_ff.start;
            cnt_in        = cnt_ff + 1'b1;
            state_in      = ffsa_pkg::S_DONE;
         end

         ffsa_pkg::S_MG_START: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            idx_in   = '0;
            state_in = ffsa_pkg::S_MG_LOAD;
         end

         ffsa_pkg::S_MG_LOAD: begin
            a_in = rd_ff;
            if (cnt_ext > CW'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(1);
               state_in = ffsa_pkg::S_MG_CMP;
            end else begin
               state_in = ffsa_pkg::S_DONE;
            end
         end

         // a_ff is entry idx, rd_ff is entry idx+1
         ffsa_pkg::S_MG_CMP: begin
            if (a_ff.free && rd_ff.free) begin
               a_in.size    = alu.merged_size;
               wr_en        = 1'b1;
               wr_addr      = idx_ff;
               wr_data      = a_ff;
               wr_data.size = alu.merged_size;
               k_in         = idx_ff + 1'b1;
               state_in     = ffsa_pkg::S_DN;
            end else begin
               a_in   = rd_ff;
               idx_in = idx_ff + 1'b1;
               if (idx_ext + CW'(2) < cnt_ext) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(idx_ext + CW'(2));
               end else begin
                  state_in = ffsa_pkg::S_DONE;
               end
            end
         end

         // close the gap at k by moving entries down one place
         ffsa_pkg::S_DN: begin
            if (k_ext + CW'(1) < cnt_ext) begin
               rd_en    = 1'b1;
               rd_addr  = k_ff + 1'b1;
               state_in = ffsa_pkg::S_DN_WR;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (idx_ext + CW'(2) < cnt_ext) begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + 1'b1;
                  state_in = ffsa_pkg::S_MG_CMP;
               end else begin
                  state_in = ffsa_pkg::S_DONE;
               end
            end
         end

         ffsa_pkg::S_DN_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_data  = rd_ff;
            k_in     = k_ff + 1'b1;
            state_in = ffsa_pkg::S_DN;
         end

         ffsa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               state_in      = ffsa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ffsa_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_off_ff, rsp_status_ff};

endmodule
